### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros; empty bodies when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst, expr, msg)

`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg)

`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

### rtl/dcf_pkg.sv
// ----------------------------------------------------------------------------
// dcf_pkg
// Types, command codes and decode helpers for the display command filter.
// ----------------------------------------------------------------------------
package dcf_pkg;

  localparam logic [3:0] MIN_COLUMN_RESET = 4'h2;

  localparam logic [3:0] NIB_COL_LOW  = 4'h0;
  localparam logic [3:0] NIB_COL_HIGH = 4'h1;
  localparam logic [7:0] PAGE_MASK    = 8'hF8;
  localparam logic [7:0] PAGE_BASE    = 8'hB0;

  localparam logic [7:0] CMD_MEM_MODE    = 8'h20;
  localparam logic [7:0] CMD_COL_ADDR    = 8'h21;
  localparam logic [7:0] CMD_PAGE_ADDR   = 8'h22;
  localparam logic [7:0] CMD_CONTRAST    = 8'h81;
  localparam logic [7:0] CMD_CHARGE_PUMP = 8'h8D;
  localparam logic [7:0] CMD_MUX_RATIO   = 8'hA8;
  localparam logic [7:0] CMD_DISP_OFFSET = 8'hD3;
  localparam logic [7:0] CMD_CLK_DIV     = 8'hD5;
  localparam logic [7:0] CMD_PRECHARGE   = 8'hD9;
  localparam logic [7:0] CMD_COM_PINS    = 8'hDA;
  localparam logic [7:0] CMD_VCOMH       = 8'hDB;

  typedef struct packed {
    logic [7:0] bus_byte;
    logic       is_data;
    logic       read_enable_n;
  } dcf_item_t;

  typedef struct packed {
    logic       emit;
    logic [7:0] out_byte;
    logic       out_is_data;
  } dcf_result_t;

  function automatic logic [1:0] params_of(input logic [7:0] cmd);
    logic [1:0] n;
    unique case (cmd)
      CMD_COL_ADDR, CMD_PAGE_ADDR: n = 2'd2;
      CMD_MEM_MODE, CMD_CONTRAST, CMD_CHARGE_PUMP, CMD_MUX_RATIO,
      CMD_DISP_OFFSET, CMD_CLK_DIV, CMD_PRECHARGE, CMD_COM_PINS,
      CMD_VCOMH: n = 2'd1;
      default: n = 2'd0;
    endcase
    return n;
  endfunction

endpackage

### rtl/dcf_in_reg.sv
// ----------------------------------------------------------------------------
// dcf_in_reg
// Input register: holds one accepted transaction until the decode consumes it.
// ----------------------------------------------------------------------------
module dcf_in_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic              go,
  input  dcf_pkg::dcf_item_t item_in,
  output logic              s1_valid,
  output dcf_pkg::dcf_item_t item
);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= item_in;
    end
  end

endmodule

### rtl/dcf_decode.sv
// ----------------------------------------------------------------------------
// dcf_decode
// Command decode, column clamp, skip counter and min_column register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dcf_decode (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [3:0]          cfg_wdata,
  input  logic                go,
  input  dcf_pkg::dcf_item_t  item,
  output dcf_pkg::dcf_result_t res
);

  logic [3:0] min_column;
  logic [1:0] skip_count;
  logic [1:0] skip_count_next;
  logic       col_low;
  logic       col_high;
  logic       page;

  assign col_low  = (item.bus_byte[7:4] == dcf_pkg::NIB_COL_LOW);
  assign col_high = (item.bus_byte[7:4] == dcf_pkg::NIB_COL_HIGH);
  assign page     = ((item.bus_byte & dcf_pkg::PAGE_MASK) == dcf_pkg::PAGE_BASE);

  always_comb begin
    res             = '0;
    skip_count_next = skip_count;
    priority if (skip_count != 2'd0) begin
      skip_count_next = skip_count - 2'd1;
    end else if (!item.read_enable_n) begin
      res.emit = 1'b0;
    end else if (item.is_data) begin
      res.emit        = 1'b1;
      res.out_byte    = item.bus_byte;
      res.out_is_data = 1'b1;
    end else if (col_low) begin
      res.emit     = 1'b1;
      res.out_byte = (item.bus_byte[3:0] < min_column) ? {4'h0, min_column} : item.bus_byte;
    end else if (col_high || page) begin
      res.emit     = 1'b1;
      res.out_byte = item.bus_byte;
    end else begin
      skip_count_next = dcf_pkg::params_of(item.bus_byte);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      skip_count <= 2'd0;
    end else if (go) begin
      skip_count <= skip_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_column <= dcf_pkg::MIN_COLUMN_RESET;
    end else if (cfg_we) begin
      min_column <= cfg_wdata;
    end
  end

  `ASSERT_IMPLY(a_emit_no_skip, clk, rst, res.emit, skip_count == 2'd0, "emit while skipping")
  `ASSERT_NEXT(a_skip_dec, clk, rst, go && (skip_count != 2'd0), skip_count == ($past(skip_count) - 2'd1), "skip count did not decrement")
  `ASSERT_IMPLY(a_col_clamp, clk, rst, res.emit && !res.out_is_data && (res.out_byte[7:4] == dcf_pkg::NIB_COL_LOW), res.out_byte[3:0] >= min_column, "column below minimum")
  `ASSERT_IMPLY(a_data_passes, clk, rst, res.out_is_data, res.emit && (res.out_byte == item.bus_byte), "data byte altered")

endmodule

### rtl/dcf_out_reg.sv
// ----------------------------------------------------------------------------
// dcf_out_reg
// Result register: holds one result transaction until the receiver takes it.
// ----------------------------------------------------------------------------
module dcf_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                go,
  input  dcf_pkg::dcf_result_t res,
  input  logic                out_stall,
  output logic                out_valid,
  output logic [7:0]          out_byte,
  output logic                out_is_data
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go) begin
      out_valid <= res.emit;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && res.emit) begin
      out_byte    <= res.out_byte;
      out_is_data <= res.out_is_data;
    end
  end

endmodule

### rtl/display_command_filter.sv
// ----------------------------------------------------------------------------
// display_command_filter
// Filters a host display bus: forwards data, column and page commands only.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with bus_byte, is_data, read_enable_n,
// one transaction per bus strobe. Output channel: out_valid / out_stall with
// out_byte, out_is_data; a transaction moves when valid is high and stall low.
// Each input transaction yields zero or one output transaction.
// Each accepted transaction passes through the input register, then the
// decode, and its result is presented from the result register.
// One transaction per cycle while the result register is not stalled, set by
// the single decode step between the two registers; the skip counter updates
// as each transaction leaves the input register.
// When out_stall holds a result, the input register can still take one more
// transaction; in_stall rises only once both registers are full.
// min_column is written by the user with cfg_we / cfg_wdata while the block
// is idle; the block itself does not enforce this. Reset (rst, synchronous)
// empties both registers, clears the skip counter and sets min_column to 2.
// ----------------------------------------------------------------------------
module display_command_filter (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [3:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] bus_byte,
  input  logic       is_data,
  input  logic       read_enable_n,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_is_data
);

  logic                 s1_valid;
  logic                 go;
  logic                 accept;
  dcf_pkg::dcf_item_t   item_in;
  dcf_pkg::dcf_item_t   item;
  dcf_pkg::dcf_result_t res;

  assign go       = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !go;
  assign accept   = in_valid && !in_stall;

  assign item_in.bus_byte      = bus_byte;
  assign item_in.is_data       = is_data;
  assign item_in.read_enable_n = read_enable_n;

  dcf_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .go       (go),
    .item_in  (item_in),
    .s1_valid (s1_valid),
    .item     (item)
  );

  dcf_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .go        (go),
    .item      (item),
    .res       (res)
  );

  dcf_out_reg u_out_reg (
    .clk         (clk),
    .rst         (rst),
    .go          (go),
    .res         (res),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_byte    (out_byte),
    .out_is_data (out_is_data)
  );

endmodule
